>>> design/mspf_pkg.sv
// shared constants, codes and types of the motor speed regulator
`timescale 1ns / 1ps
package mspf_pkg;

    localparam int TABLE_ENTRIES = 11;
    localparam int TBL_AW = $clog2(TABLE_ENTRIES);
    localparam logic [TBL_AW-1:0] TBL_LAST = TBL_AW'(TABLE_ENTRIES - 1);

    localparam int IDX_W    = 4;
    localparam int SPEED_W  = 16;
    localparam int DUTY_W   = 10;
    localparam int TGT_W    = 16;
    localparam int TICK_W   = 16;
    localparam int MS_W     = 10;
    localparam int US_W     = 20;
    localparam int MEAS_W   = 26;
    localparam int PT_W     = 32;
    localparam int PM_W     = 16;
    localparam int GAIN_W   = 32;
    localparam int PWMB_W   = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int ERR_W  = 27;
    localparam int DIFF_W = 28;
    localparam int DER_W  = 49;
    localparam int SUM_W  = 27;
    localparam int TOT_W  = 27;
    localparam int NOFB_W = 66;
    localparam int FF_W   = 13;
    localparam int MUL_A_W = 27;
    localparam int MUL_P_W = MUL_A_W + GAIN_W;

    localparam int DIV_NUM_W = 64;
    localparam int DIV_DEN_W = 20;
    localparam int DIV_STEPS = DIV_NUM_W / 2;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // integral step |e*us| is clipped where the sum saturates anyway, then
    // scaled by 65536/1000 as floor(m * ceil(2^41/125) / 2^28)
    localparam int INC_M_W   = 21;
    localparam int RECIP_W   = 35;
    localparam int INC_P_W   = INC_M_W + RECIP_W;
    localparam int INC_SHIFT = 28;
    localparam int INC_Q_W   = INC_P_W - INC_SHIFT;
    localparam logic [INC_M_W-1:0] INC_M_MAX = 21'd2000000;
    localparam logic [RECIP_W-1:0] INC_RECIP = 35'd17592186045;

    localparam int  FRAC_W     = 16;
    localparam int  MS_SCALE   = 1000;
    localparam longint SPEED_MAX = 33554431;
    localparam longint SPEED_MIN = -33554432;
    localparam longint DER_LIM   = 64'sd140737488355328;
    localparam longint SUM_LIM   = 65536000;
    localparam longint OUT_LIM   = 67043328;
    localparam logic [PWMB_W-1:0] PWMB_MAX   = 5'd16;
    localparam logic [PWMB_W-1:0] PWMB_RESET = 5'd10;

    localparam logic CMD_TABLE   = 1'b0;
    localparam logic CMD_CONTROL = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_PROP     = 3'd0,
        REG_GAIN_INTEGRAL = 3'd1,
        REG_GAIN_DERIV    = 3'd2,
        REG_PWM_BITS      = 3'd3
    } cfg_reg_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_ACC,
        OP_SPD_PREP,
        OP_SPD_DONE,
        OP_ERR,
        OP_PMUL,
        OP_DER_PREP,
        OP_DER_DONE,
        OP_DLO,
        OP_DHI,
        OP_DSUM,
        OP_FF_RD0,
        OP_FF_RDL,
        OP_FF_RDN,
        OP_FF_TAKE,
        OP_FF_IPREP,
        OP_FF_IDONE,
        OP_NOFB,
        OP_INC_PREP,
        OP_INC_DONE,
        OP_IMUL,
        OP_TOTAL,
        OP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic pm_nz;
        logic us_zero;
        logic div_busy;
        logic cur_ge_tps;
        logic tps_ge_cur;
        logic gate_ok;
    } dp_status_t;

endpackage

>>> design/motor_speed_pid_feedforward_unit.sv
// A table write gives no result; a control word gives one unless elapsed_us is zero,
// its work set by up to three passes of the shared divider (speed estimate,
// derivative, interpolation) plus a scan of the feedforward table.
// One word is taken at a time; after a control word with a result the next word is
// taken once the result sits in the output register. Reset clears counters, estimate,
// integral and gains, sets pwm_bits to 10; the feedforward table is not cleared.
`timescale 1ns / 1ps
module motor_speed_pid_feedforward_unit
    import mspf_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     command,
    input  logic [IDX_W-1:0]         entry_index,
    input  logic [SPEED_W-1:0]       entry_speed,
    input  logic [DUTY_W-1:0]        entry_duty,
    input  logic signed [TGT_W-1:0]  target_speed,
    input  logic signed [TICK_W-1:0] tick_delta,
    input  logic [MS_W-1:0]          elapsed_ms,
    input  logic [US_W-1:0]          elapsed_us,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     direction,
    output logic [DUTY_W-1:0]        duty,
    output logic signed [MEAS_W-1:0] measured_speed
);

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    mspf_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_command (command),
        .in_ready   (in_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .cmd        (cmd),
        .status     (status)
    );

    mspf_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .command        (command),
        .entry_index    (entry_index),
        .entry_speed    (entry_speed),
        .entry_duty     (entry_duty),
        .target_speed   (target_speed),
        .tick_delta     (tick_delta),
        .elapsed_ms     (elapsed_ms),
        .elapsed_us     (elapsed_us),
        .direction      (direction),
        .duty           (duty),
        .measured_speed (measured_speed)
    );

endmodule

>>> design/mspf_divider.sv
// shared unsigned restoring divider, two quotient bits per cycle
`timescale 1ns / 1ps
module mspf_divider
    import mspf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_NUM_W-1:0] num,
    input  logic [DIV_DEN_W-1:0] den,
    output logic                 busy,
    output logic [DIV_NUM_W-1:0] quo
);

    logic                 busy_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_NUM_W-1:0] quo_reg;

    logic [DIV_DEN_W:0]   t1;
    logic [DIV_DEN_W:0]   t2;
    logic [DIV_DEN_W-1:0] r1;
    logic [DIV_DEN_W-1:0] r2;
    logic                 q1;
    logic                 q2;

    always_comb
    begin
        t1 = {rem_reg, quo_reg[DIV_NUM_W-1]};
        q1 = (t1 >= {1'b0, den_reg});
        r1 = q1 ? DIV_DEN_W'(t1 - {1'b0, den_reg}) : t1[DIV_DEN_W-1:0];
        t2 = {r1, quo_reg[DIV_NUM_W-2]};
        q2 = (t2 >= {1'b0, den_reg});
        r2 = q2 ? DIV_DEN_W'(t2 - {1'b0, den_reg}) : t2[DIV_DEN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            den_reg <= den;
            quo_reg <= num;
        end
        else if (busy_reg)
        begin
            rem_reg <= r2;
            quo_reg <= {quo_reg[DIV_NUM_W-3:0], q1, q2};
        end
    end

    assign busy = busy_reg;
    assign quo  = quo_reg;

endmodule

>>> design/mspf_datapath.sv
// datapath: regulator state, gains, feedforward table, multiplier and divider
`timescale 1ns / 1ps
module mspf_datapath
    import mspf_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  dp_cmd_t                  cmd,
    output dp_status_t               status,
    input  logic                     cfg_valid,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    input  logic                     command,
    input  logic [IDX_W-1:0]         entry_index,
    input  logic [SPEED_W-1:0]       entry_speed,
    input  logic [DUTY_W-1:0]        entry_duty,
    input  logic signed [TGT_W-1:0]  target_speed,
    input  logic signed [TICK_W-1:0] tick_delta,
    input  logic [MS_W-1:0]          elapsed_ms,
    input  logic [US_W-1:0]          elapsed_us,
    output logic                     direction,
    output logic [DUTY_W-1:0]        duty,
    output logic signed [MEAS_W-1:0] measured_speed
);

    logic [SPEED_W-1:0] tbl_speed_reg [TABLE_ENTRIES];
    logic [DUTY_W-1:0]  tbl_duty_reg  [TABLE_ENTRIES];

    logic [PT_W-1:0]           pt_reg, pt_next;
    logic [PM_W-1:0]           pm_reg, pm_next;
    logic signed [MEAS_W-1:0]  speed_reg, speed_next;
    logic signed [ERR_W-1:0]   prev_reg, prev_next;
    logic signed [SUM_W-1:0]   es_reg, es_next;
    logic signed [GAIN_W-1:0]  gp_reg, gi_reg, gd_reg;
    logic [PWMB_W-1:0]         pwmb_reg;

    logic signed [TGT_W-1:0]   target_reg;
    logic signed [TICK_W-1:0]  tick_reg;
    logic [MS_W-1:0]           ms_reg;
    logic [US_W-1:0]           us_reg;

    logic signed [ERR_W-1:0]   e_reg, e_next;
    logic [TGT_W:0]            tps_reg, tps_next;
    logic                      tneg_reg, tneg_next;
    logic signed [DER_W-1:0]   d_reg, d_next;
    logic signed [MUL_P_W-1:0] p_reg, p_next;
    logic signed [MUL_P_W-1:0] dlo_reg, dlo_next;
    logic signed [MUL_P_W-1:0] dhi_reg, dhi_next;
    logic signed [MUL_P_W-1:0] i_reg, i_next;
    logic signed [NOFB_W-1:0]  dq_reg, dq_next;
    logic signed [FF_W-1:0]    ff_reg, ff_next;
    logic signed [NOFB_W-1:0]  nofb_reg, nofb_next;
    logic signed [TOT_W-1:0]   total_reg, total_next;
    logic [TBL_AW-1:0]         idx_reg, idx_next;
    logic [SPEED_W-1:0]        xcur_reg, xcur_next, xprev_reg, xprev_next;
    logic [DUTY_W-1:0]         ycur_reg, ycur_next, yprev_reg, yprev_next;
    logic                      dneg_reg, dneg_next;
    logic                      dir_reg, dir_next;
    logic [DUTY_W-1:0]         duty_reg, duty_next;
    logic signed [MEAS_W-1:0]  meas_reg, meas_next;
    logic [INC_M_W-1:0]        inc_m_reg, inc_m_next;

    // divider hookup
    logic                 div_start;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic                 div_busy;
    logic [DIV_NUM_W-1:0] div_quo;
    logic signed [DIV_NUM_W:0] div_q_s;

    // shared multiplier
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [GAIN_W-1:0]  mul_b;
    logic signed [MUL_P_W-1:0] mul_p;

    logic signed [41:0]        spd_prod;
    logic [41:0]               spd_mag;
    logic signed [DIFF_W-1:0]  diff;
    logic [DIFF_W-1:0]         diff_mag;
    logic [DIFF_W+9:0]         der_scaled;
    logic [TGT_W:0]            ff_dx;
    logic signed [DUTY_W:0]    ff_dy;
    logic signed [28:0]        ff_prod;
    logic [28:0]               ff_mag;
    logic signed [47:0]        eus;
    logic [47:0]               eus_mag;
    logic [INC_P_W-1:0]        inc_prod;
    logic [INC_Q_W-1:0]        inc_mag;
    logic signed [NOFB_W-1:0]  inc_q;
    logic signed [ERR_W-1:0]   e_calc;
    logic signed [83:0]        dsum;
    logic signed [FF_W-1:0]    y_interp;
    logic signed [NOFB_W-1:0]  es_sum;
    logic signed [NOFB_W-1:0]  t_sum;
    logic [TOT_W-1:0]          t_mag;
    logic [DUTY_W-1:0]         out_mag;
    logic [PWMB_W-1:0]         pb;
    logic [16:0]               cap;

    mspf_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .quo   (div_quo)
    );

    assign div_q_s = dneg_reg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});

    always_comb
    begin
        mul_a = e_reg;
        mul_b = gp_reg;
        case (cmd.op)
            OP_DLO:
            begin
                mul_a = $signed({3'b000, d_reg[23:0]});
                mul_b = gd_reg;
            end
            OP_DHI:
            begin
                mul_a = MUL_A_W'($signed(d_reg[DER_W-1:24]));
                mul_b = gd_reg;
            end
            OP_IMUL:
            begin
                mul_a = MUL_A_W'(es_reg);
                mul_b = gi_reg;
            end
            default:
            begin
                mul_a = e_reg;
                mul_b = gp_reg;
            end
        endcase
        mul_p = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
    end

    always_comb
    begin
        spd_prod   = 42'($signed(pt_reg)) * 42'sd1000;
        spd_mag    = spd_prod[41] ? 42'(-spd_prod) : 42'(spd_prod);
        diff       = DIFF_W'(e_reg) - DIFF_W'(prev_reg);
        diff_mag   = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
        der_scaled = (DIFF_W+10)'(diff_mag) * (DIFF_W+10)'(MS_SCALE);
        ff_dx      = tps_reg - (TGT_W+1)'(xprev_reg);
        ff_dy      = $signed({1'b0, ycur_reg}) - $signed({1'b0, yprev_reg});
        ff_prod    = 29'($signed({1'b0, ff_dx})) * 29'(ff_dy);
        ff_mag     = ff_prod[28] ? 29'(-ff_prod) : 29'(ff_prod);
        eus        = 48'(e_reg) * 48'($signed({1'b0, us_reg}));
        eus_mag    = eus[47] ? 48'(-eus) : 48'(eus);
        inc_prod   = INC_P_W'(inc_m_reg) * INC_P_W'(INC_RECIP);
        inc_mag    = inc_prod[INC_P_W-1:INC_SHIFT];
        inc_q      = NOFB_W'($signed({1'b0, inc_mag}));
        if (dneg_reg)
        begin
            inc_q = -inc_q;
        end
        e_calc     = ERR_W'(target_reg) - ERR_W'(speed_reg);
        dsum       = (84'(dhi_reg) <<< 24) + 84'(dlo_reg);
        y_interp   = $signed({3'b000, yprev_reg}) + FF_W'(div_q_s);
        es_sum     = NOFB_W'(es_reg) + inc_q;
        t_sum      = nofb_reg + NOFB_W'(i_reg >>> FRAC_W);
        t_mag      = total_reg[TOT_W-1] ? TOT_W'(-total_reg) : TOT_W'(total_reg);
        out_mag    = t_mag[FRAC_W +: DUTY_W];
        pb         = (pwmb_reg > PWMB_MAX) ? PWMB_MAX : pwmb_reg;
        cap        = 17'((17'd1 << pb) - 17'd1);
    end

    always_comb
    begin
        div_start = 1'b0;
        div_num   = 64'(spd_mag);
        div_den   = DIV_DEN_W'(pm_reg);
        dneg_next = dneg_reg;
        case (cmd.op)
            OP_SPD_PREP:
            begin
                div_start = 1'b1;
                div_num   = 64'(spd_mag);
                div_den   = DIV_DEN_W'(pm_reg);
                dneg_next = spd_prod[41];
            end
            OP_DER_PREP:
            begin
                div_start = 1'b1;
                div_num   = 64'({der_scaled, 16'h0000});
                div_den   = us_reg;
                dneg_next = diff[DIFF_W-1];
            end
            OP_FF_IPREP:
            begin
                div_start = 1'b1;
                div_num   = 64'(ff_mag);
                div_den   = DIV_DEN_W'(xcur_reg - xprev_reg);
                dneg_next = ff_prod[28];
            end
            OP_INC_PREP:
            begin
                dneg_next = eus[47];
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        pt_next    = pt_reg;
        pm_next    = pm_reg;
        speed_next = speed_reg;
        prev_next  = prev_reg;
        es_next    = es_reg;
        e_next     = e_reg;
        tps_next   = tps_reg;
        tneg_next  = tneg_reg;
        d_next     = d_reg;
        p_next     = p_reg;
        dlo_next   = dlo_reg;
        dhi_next   = dhi_reg;
        i_next     = i_reg;
        dq_next    = dq_reg;
        ff_next    = ff_reg;
        nofb_next  = nofb_reg;
        total_next = total_reg;
        idx_next   = idx_reg;
        xcur_next  = xcur_reg;
        xprev_next = xprev_reg;
        ycur_next  = ycur_reg;
        yprev_next = yprev_reg;
        dir_next   = dir_reg;
        duty_next  = duty_reg;
        meas_next  = meas_reg;
        inc_m_next = inc_m_reg;
        case (cmd.op)
            OP_ACC:
            begin
                pt_next = pt_reg + PT_W'(tick_reg);
                pm_next = pm_reg + PM_W'(ms_reg);
            end
            OP_SPD_DONE:
            begin
                if (div_q_s > SPEED_MAX)
                begin
                    speed_next = MEAS_W'(SPEED_MAX);
                end
                else if (div_q_s < SPEED_MIN)
                begin
                    speed_next = MEAS_W'(SPEED_MIN);
                end
                else
                begin
                    speed_next = MEAS_W'(div_q_s);
                end
                pt_next = '0;
                pm_next = '0;
            end
            OP_ERR:
            begin
                e_next    = e_calc;
                tneg_next = target_reg[TGT_W-1];
                tps_next  = target_reg[TGT_W-1] ? (TGT_W+1)'(-(TGT_W+1)'(target_reg))
                                                : (TGT_W+1)'(target_reg);
                // zero target restarts the integral and kills the derivative
                if (target_reg == '0)
                begin
                    es_next   = '0;
                    prev_next = e_calc;
                end
            end
            OP_PMUL:
            begin
                p_next = mul_p;
            end
            OP_DER_DONE:
            begin
                if (div_q_s > DER_LIM)
                begin
                    d_next = DER_W'(DER_LIM);
                end
                else if (div_q_s < -DER_LIM)
                begin
                    d_next = DER_W'(-DER_LIM);
                end
                else
                begin
                    d_next = DER_W'(div_q_s);
                end
            end
            OP_DLO:
            begin
                dlo_next = mul_p;
            end
            OP_DHI:
            begin
                dhi_next = mul_p;
            end
            OP_DSUM:
            begin
                dq_next = NOFB_W'(dsum >>> FRAC_W);
            end
            OP_FF_RD0:
            begin
                xcur_next = tbl_speed_reg[0];
                ycur_next = tbl_duty_reg[0];
                idx_next  = TBL_AW'(1);
            end
            OP_FF_RDL:
            begin
                xcur_next = tbl_speed_reg[TBL_LAST];
                ycur_next = tbl_duty_reg[TBL_LAST];
            end
            OP_FF_RDN:
            begin
                xprev_next = xcur_reg;
                yprev_next = ycur_reg;
                xcur_next  = tbl_speed_reg[idx_reg];
                ycur_next  = tbl_duty_reg[idx_reg];
                idx_next   = idx_reg + 1'b1;
            end
            OP_FF_TAKE:
            begin
                ff_next = tneg_reg ? -$signed({3'b000, ycur_reg})
                                   : $signed({3'b000, ycur_reg});
            end
            OP_FF_IDONE:
            begin
                ff_next = tneg_reg ? -y_interp : y_interp;
            end
            OP_NOFB:
            begin
                nofb_next = (NOFB_W'(ff_reg) <<< FRAC_W) + NOFB_W'(p_reg) + dq_reg;
            end
            OP_INC_PREP:
            begin
                // beyond this the sum saturates whatever its old value
                inc_m_next = (eus_mag >= 48'(INC_M_MAX)) ? INC_M_MAX
                                                         : eus_mag[INC_M_W-1:0];
            end
            OP_INC_DONE:
            begin
                if (es_sum > SUM_LIM)
                begin
                    es_next = SUM_W'(SUM_LIM);
                end
                else if (es_sum < -SUM_LIM)
                begin
                    es_next = SUM_W'(-SUM_LIM);
                end
                else
                begin
                    es_next = SUM_W'(es_sum);
                end
            end
            OP_IMUL:
            begin
                i_next = mul_p;
            end
            OP_TOTAL:
            begin
                if (t_sum > OUT_LIM)
                begin
                    total_next = TOT_W'(OUT_LIM);
                end
                else if (t_sum < -OUT_LIM)
                begin
                    total_next = TOT_W'(-OUT_LIM);
                end
                else
                begin
                    total_next = TOT_W'(t_sum);
                end
            end
            OP_OUT:
            begin
                // truncation toward zero: magnitude of the integer part
                dir_next  = total_reg[TOT_W-1] && (out_mag != '0);
                duty_next = (17'(out_mag) > cap) ? DUTY_W'(cap) : out_mag;
                meas_next = speed_reg;
                prev_next = e_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pt_reg    <= '0;
            pm_reg    <= '0;
            speed_reg <= '0;
            prev_reg  <= '0;
            es_reg    <= '0;
            gp_reg    <= '0;
            gi_reg    <= '0;
            gd_reg    <= '0;
            pwmb_reg  <= PWMB_RESET;
        end
        else
        begin
            pt_reg    <= pt_next;
            pm_reg    <= pm_next;
            speed_reg <= speed_next;
            prev_reg  <= prev_next;
            es_reg    <= es_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_GAIN_PROP:     gp_reg   <= $signed(cfg_data);
                    REG_GAIN_INTEGRAL: gi_reg   <= $signed(cfg_data);
                    REG_GAIN_DERIV:    gd_reg   <= $signed(cfg_data);
                    REG_PWM_BITS:      pwmb_reg <= cfg_data[PWMB_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_LOAD)
        begin
            target_reg <= target_speed;
            tick_reg   <= tick_delta;
            ms_reg     <= elapsed_ms;
            us_reg     <= elapsed_us;
            if (command == CMD_TABLE && entry_index < IDX_W'(TABLE_ENTRIES))
            begin
                tbl_speed_reg[entry_index[TBL_AW-1:0]] <= entry_speed;
                tbl_duty_reg[entry_index[TBL_AW-1:0]]  <= entry_duty;
            end
        end
        e_reg     <= e_next;
        tps_reg   <= tps_next;
        tneg_reg  <= tneg_next;
        d_reg     <= d_next;
        p_reg     <= p_next;
        dlo_reg   <= dlo_next;
        dhi_reg   <= dhi_next;
        i_reg     <= i_next;
        dq_reg    <= dq_next;
        ff_reg    <= ff_next;
        nofb_reg  <= nofb_next;
        total_reg <= total_next;
        idx_reg   <= idx_next;
        xcur_reg  <= xcur_next;
        xprev_reg <= xprev_next;
        ycur_reg  <= ycur_next;
        yprev_reg <= yprev_next;
        dneg_reg  <= dneg_next;
        dir_reg   <= dir_next;
        duty_reg  <= duty_next;
        meas_reg  <= meas_next;
        inc_m_reg <= inc_m_next;
    end

    always_comb
    begin
        status.pm_nz      = (pm_reg != '0);
        status.us_zero    = (us_reg == '0);
        status.div_busy   = div_busy;
        status.cur_ge_tps = ((TGT_W+1)'(xcur_reg) >= tps_reg);
        status.tps_ge_cur = (tps_reg >= (TGT_W+1)'(xcur_reg));
        status.gate_ok    = (nofb_reg < OUT_LIM) && (nofb_reg > -OUT_LIM);
    end

    assign direction      = dir_reg;
    assign duty           = duty_reg;
    assign measured_speed = meas_reg;

endmodule

>>> design/mspf_ctrl.sv
// controller: sequences one item through the datapath and owns the input and output handshakes
`timescale 1ns / 1ps
module mspf_ctrl
    import mspf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_command,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    output dp_cmd_t    cmd,
    input  dp_status_t status
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_ACC,
        S_SPD,
        S_SPD_WAIT,
        S_SPD_DONE,
        S_ERR,
        S_PMUL,
        S_DER,
        S_DER_WAIT,
        S_DER_DONE,
        S_DLO,
        S_DHI,
        S_DSUM,
        S_FF_R0,
        S_FF_C0,
        S_FF_CL,
        S_FF_SCAN,
        S_FF_CHK,
        S_FF_WAIT,
        S_FF_DONE,
        S_NOFB,
        S_GATE,
        S_INC_WAIT,
        S_INC_DONE,
        S_IMUL,
        S_TOTAL,
        S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op = OP_LOAD;
                    state_next = (in_command == CMD_CONTROL) ? S_ACC : S_IDLE;
                end
            end
            S_ACC:
            begin
                cmd.op = OP_ACC;
                state_next = S_SPD;
            end
            S_SPD:
            begin
                if (status.pm_nz)
                begin
                    cmd.op = OP_SPD_PREP;
                    state_next = S_SPD_WAIT;
                end
                else
                begin
                    state_next = status.us_zero ? S_IDLE : S_ERR;
                end
            end
            S_SPD_WAIT:
            begin
                if (!status.div_busy)
                begin
                    state_next = S_SPD_DONE;
                end
            end
            S_SPD_DONE:
            begin
                cmd.op = OP_SPD_DONE;
                state_next = status.us_zero ? S_IDLE : S_ERR;
            end
            S_ERR:
            begin
                cmd.op = OP_ERR;
                state_next = S_PMUL;
            end
            S_PMUL:
            begin
                cmd.op = OP_PMUL;
                state_next = S_DER;
            end
            S_DER:
            begin
                cmd.op = OP_DER_PREP;
                state_next = S_DER_WAIT;
            end
            S_DER_WAIT:
            begin
                if (!status.div_busy)
                begin
                    state_next = S_DER_DONE;
                end
            end
            S_DER_DONE:
            begin
                cmd.op = OP_DER_DONE;
                state_next = S_DLO;
            end
            S_DLO:
            begin
                cmd.op = OP_DLO;
                state_next = S_DHI;
            end
            S_DHI:
            begin
                cmd.op = OP_DHI;
                state_next = S_DSUM;
            end
            S_DSUM:
            begin
                cmd.op = OP_DSUM;
                state_next = S_FF_R0;
            end
            S_FF_R0:
            begin
                cmd.op = OP_FF_RD0;
                state_next = S_FF_C0;
            end
            S_FF_C0:
            begin
                // at or below the first point
                if (status.cur_ge_tps)
                begin
                    cmd.op = OP_FF_TAKE;
                    state_next = S_NOFB;
                end
                else
                begin
                    cmd.op = OP_FF_RDL;
                    state_next = S_FF_CL;
                end
            end
            S_FF_CL:
            begin
                // at or above the last point
                if (status.tps_ge_cur)
                begin
                    cmd.op = OP_FF_TAKE;
                    state_next = S_NOFB;
                end
                else
                begin
                    cmd.op = OP_FF_RD0;
                    state_next = S_FF_SCAN;
                end
            end
            S_FF_SCAN:
            begin
                cmd.op = OP_FF_RDN;
                state_next = S_FF_CHK;
            end
            S_FF_CHK:
            begin
                if (status.cur_ge_tps)
                begin
                    cmd.op = OP_FF_IPREP;
                    state_next = S_FF_WAIT;
                end
                else
                begin
                    cmd.op = OP_FF_RDN;
                end
            end
            S_FF_WAIT:
            begin
                if (!status.div_busy)
                begin
                    state_next = S_FF_DONE;
                end
            end
            S_FF_DONE:
            begin
                cmd.op = OP_FF_IDONE;
                state_next = S_NOFB;
            end
            S_NOFB:
            begin
                cmd.op = OP_NOFB;
                state_next = S_GATE;
            end
            S_GATE:
            begin
                if (status.gate_ok)
                begin
                    cmd.op = OP_INC_PREP;
                    state_next = S_INC_WAIT;
                end
                else
                begin
                    cmd.op = OP_IMUL;
                    state_next = S_TOTAL;
                end
            end
            S_INC_WAIT:
            begin
                if (!status.div_busy)
                begin
                    state_next = S_INC_DONE;
                end
            end
            S_INC_DONE:
            begin
                cmd.op = OP_INC_DONE;
                state_next = S_IMUL;
            end
            S_IMUL:
            begin
                cmd.op = OP_IMUL;
                state_next = S_TOTAL;
            end
            S_TOTAL:
            begin
                cmd.op = OP_TOTAL;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op = OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.op == OP_OUT)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

>>> design/mspf_checker.sv
// port-level checks of the regulator, bound to the top level
`timescale 1ns / 1ps
module mspf_checker
    import mspf_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_ready,
    input logic                     command,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic                     direction,
    input logic [DUTY_W-1:0]        duty,
    input logic signed [MEAS_W-1:0] measured_speed
);

    // a waiting result word holds still
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(duty) && $stable(direction)
            && $stable(measured_speed))
        else $error("result word changed while stalled");

    // a control word keeps the input side closed while it is worked on
    a_busy_after_ctrl: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && command == CMD_CONTROL |=> !in_ready)
        else $error("input taken during a control step");

    // a table write never produces a result
    a_table_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && command == CMD_TABLE && !out_valid |=> !out_valid)
        else $error("result after a table write");

    // a new result only comes out of a step in progress
    a_result_from_step: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result appeared while idle");

endmodule

bind motor_speed_pid_feedforward_unit mspf_checker u_mspf_checker (.*);

>>> tb/sv/tb_motor_speed_pid_feedforward_unit.sv
// testbench for the motor speed regulator: table writes, control steps, gains and stalls
`timescale 1ns / 1ps
module tb_motor_speed_pid_feedforward_unit;
    import mspf_pkg::*;

    localparam int STALL_MAX = 18;
    localparam int DRAIN_CYCLES = 200;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 20000;
    localparam int N_RANDOM_PHASE = 100;

    typedef struct {
        logic                     cmd;
        logic [IDX_W-1:0]         idx;
        logic [SPEED_W-1:0]       spd;
        logic [DUTY_W-1:0]        dty;
        logic signed [TGT_W-1:0]  tgt;
        logic signed [TICK_W-1:0] tick;
        logic [MS_W-1:0]          ms;
        logic [US_W-1:0]          us;
    } word_t;

    typedef struct {
        logic                     dir;
        logic [DUTY_W-1:0]        dty;
        logic signed [MEAS_W-1:0] meas;
    } drive_t;

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic command;
    logic [IDX_W-1:0] entry_index;
    logic [SPEED_W-1:0] entry_speed;
    logic [DUTY_W-1:0] entry_duty;
    logic signed [TGT_W-1:0] target_speed;
    logic signed [TICK_W-1:0] tick_delta;
    logic [MS_W-1:0] elapsed_ms;
    logic [US_W-1:0] elapsed_us;
    logic out_valid;
    logic out_ready;
    logic direction;
    logic [DUTY_W-1:0] duty;
    logic signed [MEAS_W-1:0] measured_speed;

    // regulator state mirrored by the testbench
    logic [SPEED_W-1:0] ff_spd[TABLE_ENTRIES];
    logic [DUTY_W-1:0]  ff_dty[TABLE_ENTRIES];
    int                 acc_ticks = 0;
    logic [PM_W-1:0]    acc_ms = '0;
    int                 spd_est = 0;
    int                 last_err = 0;
    int                 integ = 0;
    int                 kp = 0;
    int                 ki = 0;
    int                 kd = 0;
    logic [PWMB_W-1:0]  pwm_res = PWMB_RESET;

    drive_t expected_drive[$];
    int     n_words = 0;
    int     n_checked = 0;
    int     n_mismatch = 0;
    int     idle_cycles = 0;
    bit     no_gaps = 0;
    bit     hold_req = 0;

    motor_speed_pid_feedforward_unit i_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .command(command), .entry_index(entry_index),
        .entry_speed(entry_speed), .entry_duty(entry_duty),
        .target_speed(target_speed), .tick_delta(tick_delta),
        .elapsed_ms(elapsed_ms), .elapsed_us(elapsed_us),
        .out_valid(out_valid), .out_ready(out_ready),
        .direction(direction), .duty(duty), .measured_speed(measured_speed)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic longint floor_q(longint x);
        return x >= 0 ? x / 65536 : -((-x + 65535) / 65536);
    endfunction

    // floor(a*g/2^16) without overflowing 64 bits
    function automatic longint gain_mul(longint a, int g);
        longint hi;
        longint lo;
        hi = floor_q(a);
        lo = a - hi * 65536;
        return hi * longint'(g) + floor_q(lo * longint'(g));
    endfunction

    function automatic longint clamp(longint x, longint lo, longint hi);
        return x < lo ? lo : (x > hi ? hi : x);
    endfunction

    function automatic longint ff_interp(longint tgt);
        longint tps;
        longint y;
        longint x0;
        longint x1;
        longint y0;
        longint y1;
        tps = tgt < 0 ? -tgt : tgt;
        y = 0;
        if (tps <= longint'(ff_spd[0]))
            y = longint'(ff_dty[0]);
        else if (tps >= longint'(ff_spd[TABLE_ENTRIES-1]))
            y = longint'(ff_dty[TABLE_ENTRIES-1]);
        else
        begin
            for (int i = 1; i < TABLE_ENTRIES; i++)
            begin
                if (longint'(ff_spd[i]) >= tps)
                begin
                    x0 = longint'(ff_spd[i-1]);
                    x1 = longint'(ff_spd[i]);
                    y0 = longint'(ff_dty[i-1]);
                    y1 = longint'(ff_dty[i]);
                    y = y0 + (tps - x0) * (y1 - y0) / (x1 - x0);
                    break;
                end
            end
        end
        return tgt < 0 ? -y : y;
    endfunction

    // one regulator step; returns 1 when a drive word comes out
    function automatic bit regulate(word_t w, output drive_t r);
        longint tgt;
        longint us;
        longint e;
        longint d;
        longint nofb;
        longint total;
        longint v;
        longint mag;
        longint cap;
        int     pb;
        r = '{default: '0};
        if (w.cmd == CMD_TABLE)
        begin
            if (w.idx < TABLE_ENTRIES)
            begin
                ff_spd[w.idx] = w.spd;
                ff_dty[w.idx] = w.dty;
            end
            return 0;
        end
        tgt = longint'(w.tgt);
        acc_ticks = acc_ticks + int'(w.tick);
        acc_ms = acc_ms + PM_W'(w.ms);
        if (acc_ms != 0)
        begin
            spd_est = int'(clamp(longint'(acc_ticks) * 1000 / longint'(acc_ms),
                                 SPEED_MIN, SPEED_MAX));
            acc_ticks = 0;
            acc_ms = '0;
        end
        if (w.us == 0)
            return 0;
        us = longint'(w.us);
        e = tgt - longint'(spd_est);
        if (tgt == 0)
        begin
            integ = 0;
            last_err = int'(e);
        end
        d = clamp((e - longint'(last_err)) * 65536000 / us, -DER_LIM, DER_LIM);
        nofb = ff_interp(tgt) * 65536 + gain_mul(e * 65536, kp) + gain_mul(d, kd);
        // anti-windup: integrate only while the other terms are off the limit
        if (nofb < OUT_LIM && nofb > -OUT_LIM)
            integ = int'(clamp(longint'(integ) + e * us * 65536 / 1000, -SUM_LIM, SUM_LIM));
        total = clamp(nofb + gain_mul(longint'(integ), ki), -OUT_LIM, OUT_LIM);
        v = total / 65536;
        last_err = int'(e);
        mag = v < 0 ? -v : v;
        pb = pwm_res > PWMB_MAX ? int'(PWMB_MAX) : int'(pwm_res);
        cap = (longint'(1) << pb) - 1;
        if (mag > cap)
            mag = cap;
        r.dir = v < 0;
        r.dty = mag[DUTY_W-1:0];
        r.meas = spd_est[MEAS_W-1:0];
        return 1;
    endfunction

    // acceptance monitor, predictor and checker
    always @(posedge clk)
    begin
        word_t  w;
        drive_t exp_d;
        bit     any;
        any = 0;
        if (out_valid && out_ready)
        begin
            any = 1;
            if (expected_drive.size() == 0)
            begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("unexpected drive word dir=%0d duty=%0d speed=%0d",
                             direction, duty, measured_speed);
            end
            else
            begin
                exp_d = expected_drive.pop_front();
                n_checked++;
                if (direction !== exp_d.dir || duty !== exp_d.dty
                    || measured_speed !== exp_d.meas)
                begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("drive word %0d: expected dir=%0d duty=%0d speed=%0d, got dir=%0d duty=%0d speed=%0d",
                                 n_checked, exp_d.dir, exp_d.dty, exp_d.meas,
                                 direction, duty, measured_speed);
                end
            end
        end
        if (in_valid && in_ready)
        begin
            any = 1;
            w.cmd = command;
            w.idx = entry_index;
            w.spd = entry_speed;
            w.dty = entry_duty;
            w.tgt = target_speed;
            w.tick = tick_delta;
            w.ms = elapsed_ms;
            w.us = elapsed_us;
            if (regulate(w, exp_d))
                expected_drive.push_back(exp_d);
        end
        if (cfg_valid && cfg_ready)
        begin
            any = 1;
            case (cfg_index)
                REG_GAIN_PROP:     kp = cfg_data;
                REG_GAIN_INTEGRAL: ki = cfg_data;
                REG_GAIN_DERIV:    kd = cfg_data;
                REG_PWM_BITS:      pwm_res = cfg_data[PWMB_W-1:0];
                default: ;
            endcase
        end
        idle_cycles = any ? 0 : idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("tb_motor_speed_pid_feedforward_unit: done, errors");
            $finish;
        end
    end

    // receiver side: random stalls, one long hold on request
    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 0;
            end
            stall = no_gaps ? 0 : $urandom_range(0, STALL_MAX);
            if (stall > 0)
            begin
                out_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready = 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_word(word_t w);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, STALL_MAX);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        command = w.cmd;
        entry_index = w.idx;
        entry_speed = w.spd;
        entry_duty = w.dty;
        target_speed = w.tgt;
        tick_delta = w.tick;
        elapsed_ms = w.ms;
        elapsed_us = w.us;
        in_valid = 1'b1;
        do @(posedge clk); while (!in_ready);
        n_words++;
        @(negedge clk);
    endtask

    // waits out all drive words, then the tail of a step that gives none
    task automatic drain();
        in_valid = 1'b0;
        while (expected_drive.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(cfg_reg_t r, logic [CFG_DATA_W-1:0] v);
        cfg_index = r;
        cfg_data = v;
        cfg_valid = 1'b1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_gains(int p, int i, int d, logic [PWMB_W-1:0] b);
        drain();
        write_reg(REG_GAIN_PROP, p);
        write_reg(REG_GAIN_INTEGRAL, i);
        write_reg(REG_GAIN_DERIV, d);
        write_reg(REG_PWM_BITS, CFG_DATA_W'(b));
    endtask

    function automatic word_t table_word(int idx, int spd, int dty);
        word_t w;
        w = '{default: '0};
        w.cmd = CMD_TABLE;
        w.idx = IDX_W'(idx);
        w.spd = SPEED_W'(spd);
        w.dty = DUTY_W'(dty);
        return w;
    endfunction

    function automatic word_t ctl_word(int tgt, int tick, int ms, int us);
        word_t w;
        w = '{default: '0};
        w.cmd = CMD_CONTROL;
        w.tgt = TGT_W'(tgt);
        w.tick = TICK_W'(tick);
        w.ms = MS_W'(ms);
        w.us = US_W'(us);
        return w;
    endfunction

    // random control word; most look like a real loop, some use full ranges
    function automatic word_t rand_ctl();
        word_t w;
        w = ctl_word(0, 0, 0, 0);
        w.tgt = TGT_W'(($urandom_range(0, 3) == 0) ? $urandom
                                                    : $urandom_range(0, 6000) - 3000);
        w.tick = TICK_W'(($urandom_range(0, 4) == 0) ? $urandom
                                                      : $urandom_range(0, 200) - 100);
        case ($urandom_range(0, 9))
            0: w.ms = '0;
            1: w.ms = MS_W'($urandom_range(0, 1000));
            default: w.ms = MS_W'($urandom_range(1, 20));
        endcase
        case ($urandom_range(0, 9))
            0: w.us = '0;
            1: w.us = US_W'($urandom_range(1, 1000000));
            default: w.us = US_W'($urandom_range(1000, 50000));
        endcase
        if ($urandom_range(0, 19) == 0)
            w.tgt = '0;
        return w;
    endfunction

    task automatic test_config_extremes();
        set_gains(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 5'd31);
        set_gains(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 5'd0);
        set_gains(2 * 65536, 65536 / 4, 65536 / 64, PWMB_RESET);
    endtask

    task automatic test_table_fill();
        for (int i = 0; i < TABLE_ENTRIES; i++)
            send_word(table_word(i, i * 3000 + 100, i * 100));
        send_word(table_word(TABLE_ENTRIES - 1, 65535, 1023));
        send_word(table_word(11, 1234, 567));
        send_word(table_word(15, 65535, 1023));
    endtask

    task automatic test_directed_steps();
        send_word(ctl_word(0, 0, 0, 1000));
        send_word(ctl_word(32767, 32767, 1, 1));
        send_word(ctl_word(-32768, -32768, 1000, 1000000));
        send_word(ctl_word(1500, 50, 0, 0));
        send_word(ctl_word(50, 10, 0, 5000));
        send_word(ctl_word(-50, -10, 5, 5000));
        send_word(ctl_word(-33000 + 500, 200, 10, 10000));
        send_word(ctl_word(0, -5, 3, 20000));
        send_word(ctl_word(4550, 40, 10, 10000));
    endtask

    task automatic test_random_steps(int n);
        word_t w;
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 9) == 0)
                w = table_word($urandom_range(0, 15), $urandom_range(0, 65535),
                               $urandom_range(0, 1023));
            else
                w = rand_ctl();
            // quiet stretch with no idling on either side
            no_gaps = (k % 40) >= 30;
            send_word(w);
        end
        no_gaps = 0;
    endtask

    task automatic test_backpressure();
        hold_req = 1;
        no_gaps = 1;
        for (int k = 0; k < 20; k++)
            send_word(rand_ctl());
        no_gaps = 0;
    endtask

    task automatic test_gain_sweep();
        test_random_steps(N_RANDOM_PHASE);
        set_gains($urandom_range(0, 8 * 65536), $urandom_range(0, 65536),
                  $urandom_range(0, 65536), 5'd16);
        test_random_steps(N_RANDOM_PHASE);
        set_gains(-int'($urandom_range(0, 65536)), $urandom_range(0, 4096), 0, 5'd1);
        test_random_steps(N_RANDOM_PHASE);
        // sender pauses until everything is back
        drain();
        test_random_steps(N_RANDOM_PHASE / 2);
        set_gains($urandom, $urandom, $urandom, PWMB_W'($urandom_range(1, 16)));
        test_random_steps(N_RANDOM_PHASE);
        set_gains(65536, 65536 / 8, 65536 / 128, 5'd8);
        test_random_steps(N_RANDOM_PHASE);
    endtask

    initial
    begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            ff_spd[i] = '0;
            ff_dty[i] = '0;
        end
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_GAIN_PROP;
        cfg_data = '0;
        in_valid = 1'b0;
        command = CMD_TABLE;
        entry_index = '0;
        entry_speed = '0;
        entry_duty = '0;
        target_speed = '0;
        tick_delta = '0;
        elapsed_ms = '0;
        elapsed_us = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_table_fill();
        test_directed_steps();
        test_config_extremes();
        test_directed_steps();
        test_backpressure();
        test_gain_sweep();
        drain();

        $display("%0d input words, %0d drive words checked over several gain and pwm settings",
                 n_words, n_checked);
        $display("table writes, idle steps, zero targets, long output hold included");
        if (n_mismatch == 0 && expected_drive.size() == 0)
            $display("tb_motor_speed_pid_feedforward_unit: done, clean");
        else
            $display("tb_motor_speed_pid_feedforward_unit: done, errors");
        $finish;
    end

endmodule
